// File: design/dbd_pkg.sv
// ----------------------------------------------------------------------------
// dbd_pkg
// Shared types and constants for the detector box decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dbd_pkg;

  localparam int MAX_BOX_FIELDS = 128;
  localparam int QUEUE_DEPTH    = 4;

  // Positions of the held fields within a box
  localparam int HELD_FIELDS = 5;
  localparam int POS_CONF    = 4;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int THRESH_W    = 17;
  localparam int SCALE_W     = 24;
  localparam int CLASS_W     = 7;
  localparam int CONF_W      = 31;
  localparam int OUT_TDATA_W = 104;

  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE_H   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE_V   = 2'd2;

  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 17'd26214;
  localparam logic [SCALE_W-1:0]  SCALE_RESET     = 24'd65536;

  // One kept box, from front to back
  typedef struct packed {
    logic signed [31:0]  x;
    logic signed [31:0]  y;
    logic signed [31:0]  w;
    logic signed [31:0]  h;
    logic [CONF_W-1:0]   conf;
    logic [CLASS_W-1:0]  class_index;
  } box_rec_t;

endpackage

`default_nettype wire

// File: design/detector_box_decode_core.sv
// ----------------------------------------------------------------------------
// detector_box_decode_core
// Detector output box decoder: argmax over class scores, threshold on the
// box confidence, scaling and centre-to-corner conversion of kept boxes.
// ----------------------------------------------------------------------------
// Throughput: one tensor element per cycle; s_tready drops only when the
//   four-entry box queue is full under output backpressure.
// Path: a kept box reaches m_tvalid through the queue write, the multiply
//   stage and the output register, after its last beat is accepted.
// Reset: clears the box state, the queue and all stage valids, and loads the
//   threshold (0.4) and both scales (1.0) with their defaults.
`default_nettype none

module detector_box_decode_core #(
  parameter int MAX_BOX_FIELDS = dbd_pkg::MAX_BOX_FIELDS
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  input  wire [31:0]                       s_tdata,   // [31:0] value
  input  wire                              s_tlast,   // box_end
  output logic                             m_tvalid,
  input  wire                              m_tready,
  // [14:0] left_x, [29:15] top_y, [45:30] box_width, [61:46] box_height,
  // [68:62] class_index, [99:69] box_confidence, [103:100] zero
  output logic [dbd_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [dbd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire [dbd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [dbd_pkg::THRESH_W-1:0] threshold;
  logic [dbd_pkg::SCALE_W-1:0]  scale_h, scale_v;

  logic                         push, full;
  dbd_pkg::box_rec_t            push_rec, pop_rec;
  logic                         pop_valid, pop_ready;

  logic [14:0]                  left_x, top_y;
  logic signed [15:0]           box_width, box_height;
  logic [dbd_pkg::CLASS_W-1:0]  class_index;
  logic [dbd_pkg::CONF_W-1:0]   box_confidence;

  assign cfg_ready = 1'b1;
  assign s_tready  = !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= dbd_pkg::THRESHOLD_RESET;
      scale_h   <= dbd_pkg::SCALE_RESET;
      scale_v   <= dbd_pkg::SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dbd_pkg::REG_THRESHOLD: threshold <= cfg_data[dbd_pkg::THRESH_W-1:0];
        dbd_pkg::REG_SCALE_H:   scale_h   <= cfg_data;
        dbd_pkg::REG_SCALE_V:   scale_v   <= cfg_data;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  dbd_front #(
    .MAX_BOX_FIELDS(MAX_BOX_FIELDS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .value     ($signed(s_tdata)),
    .box_end   (s_tlast),
    .threshold (threshold),
    .push      (push),
    .push_rec  (push_rec)
  );

  dbd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_rec  (push_rec),
    .full      (full),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_rec   (pop_rec)
  );

  dbd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (pop_valid),
    .in_ready       (pop_ready),
    .in_rec         (pop_rec),
    .scale_h        (scale_h),
    .scale_v        (scale_v),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .left_x         (left_x),
    .top_y          (top_y),
    .box_width      (box_width),
    .box_height     (box_height),
    .class_index    (class_index),
    .box_confidence (box_confidence)
  );

  assign m_tdata = {4'd0, box_confidence, class_index, box_height, box_width,
                    top_y, left_x};

endmodule

`default_nettype wire

// File: design/dbd_front.sv
// ----------------------------------------------------------------------------
// dbd_front
// Takes tensor elements, holds box fields, tracks the best class score and
// pushes a box record into the queue when a box passes the threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module dbd_front #(
  parameter int MAX_BOX_FIELDS = dbd_pkg::MAX_BOX_FIELDS
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  input  wire                          in_ready,
  input  wire signed [31:0]            value,
  input  wire                          box_end,
  input  wire [dbd_pkg::THRESH_W-1:0]  threshold,
  output logic                         push,
  output dbd_pkg::box_rec_t            push_rec
);

  localparam int POS_W = $clog2(MAX_BOX_FIELDS);
  localparam int IDX_W = (POS_W > dbd_pkg::CLASS_W) ? POS_W : dbd_pkg::CLASS_W;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_BOX_FIELDS - 1);

  logic [POS_W-1:0]            pos, pos_next;
  logic signed [31:0]          held [dbd_pkg::HELD_FIELDS];
  logic signed [31:0]          held_next [dbd_pkg::HELD_FIELDS];
  logic signed [31:0]          best_score, best_score_next;
  logic [dbd_pkg::CLASS_W-1:0] best_class, best_class_next;
  logic [IDX_W-1:0]            class_wide;
  logic                        accept;
  logic                        keep;

  assign accept     = in_valid && in_ready;
  assign class_wide = IDX_W'(pos) - IDX_W'(dbd_pkg::HELD_FIELDS);

  always_comb begin
    for (int i = 0; i < dbd_pkg::HELD_FIELDS; i++) begin
      held_next[i] = (pos == POS_W'(i)) ? value : held[i];
    end
    best_score_next = best_score;
    best_class_next = best_class;
    if (pos >= POS_W'(dbd_pkg::HELD_FIELDS) && value > best_score) begin
      best_score_next = value;
      best_class_next = class_wide[dbd_pkg::CLASS_W-1:0];
    end
    pos_next = (pos < POS_LAST) ? pos + POS_W'(1) : pos;
  end

  // Confidence must be strictly above the unsigned threshold
  assign keep = $signed({held_next[dbd_pkg::POS_CONF][31], held_next[dbd_pkg::POS_CONF]})
              > $signed({16'd0, threshold});

  assign push = accept && box_end && keep;

  always_comb begin
    push_rec.x           = held_next[0];
    push_rec.y           = held_next[1];
    push_rec.w           = held_next[2];
    push_rec.h           = held_next[3];
    push_rec.conf        = held_next[dbd_pkg::POS_CONF][dbd_pkg::CONF_W-1:0];
    push_rec.class_index = best_class_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && box_end)) begin
      pos        <= '0;
      best_score <= '0;
      best_class <= '0;
      for (int i = 0; i < dbd_pkg::HELD_FIELDS; i++) begin
        held[i] <= '0;
      end
    end else if (accept) begin
      pos        <= pos_next;
      best_score <= best_score_next;
      best_class <= best_class_next;
      for (int i = 0; i < dbd_pkg::HELD_FIELDS; i++) begin
        held[i] <= held_next[i];
      end
    end
  end

endmodule

`default_nettype wire

// File: design/dbd_queue.sv
// ----------------------------------------------------------------------------
// dbd_queue
// Short queue of kept box records between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module dbd_queue (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  dbd_pkg::box_rec_t  push_rec,
  output logic               full,
  output logic               pop_valid,
  input  wire                pop_ready,
  output dbd_pkg::box_rec_t  pop_rec
);

  localparam int DEPTH = dbd_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  dbd_pkg::box_rec_t entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_rec   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/dbd_back.sv
// ----------------------------------------------------------------------------
// dbd_back
// Scales a kept box to the original image, converts centre to corner and
// saturates, through a multiply stage and an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dbd_back (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  dbd_pkg::box_rec_t            in_rec,
  input  wire [dbd_pkg::SCALE_W-1:0]   scale_h,
  input  wire [dbd_pkg::SCALE_W-1:0]   scale_v,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [14:0]                  left_x,
  output logic [14:0]                  top_y,
  output logic signed [15:0]           box_width,
  output logic signed [15:0]           box_height,
  output logic [dbd_pkg::CLASS_W-1:0]  class_index,
  output logic [dbd_pkg::CONF_W-1:0]   box_confidence
);

  // Multiply stage
  logic                        s1_valid;
  logic signed [56:0]          px, py, pw, ph;
  logic [dbd_pkg::CLASS_W-1:0] s1_class;
  logic [dbd_pkg::CONF_W-1:0]  s1_conf;
  logic                        s1_advance;
  logic                        out_free;

  logic signed [24:0]          sx, sy;
  logic signed [58:0]          dx, dy;
  logic [14:0]                 left_next, top_next;
  logic signed [15:0]          wid_next, hei_next;

  assign out_free   = !out_valid || out_ready;
  assign s1_advance = s1_valid && out_free;
  assign in_ready   = !s1_valid || out_free;

  assign sx = $signed({1'b0, scale_h});
  assign sy = $signed({1'b0, scale_v});

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      px       <= in_rec.x * sx;
      py       <= in_rec.y * sy;
      pw       <= in_rec.w * sx;
      ph       <= in_rec.h * sy;
      s1_class <= in_rec.class_index;
      s1_conf  <= in_rec.conf;
    end
  end

  // Corner clamps at zero, so a negative difference needs no rounding
  function automatic logic [14:0] corner(input logic signed [58:0] d);
    logic [14:0] r;
    if (d[58]) begin
      r = '0;
    end else if (|d[57:48]) begin
      r = 15'h7FFF;
    end else begin
      r = d[47:33];
    end
    return r;
  endfunction

  // Truncate toward zero by 2^32, then saturate to 16 bits
  function automatic logic signed [15:0] extent(input logic signed [56:0] p);
    logic signed [24:0] q;
    logic signed [15:0] r;
    q = $signed(p[56:32]) + $signed({24'd0, p[56] && (|p[31:0])});
    if (!q[24] && (|q[23:15])) begin
      r = 16'sh7FFF;
    end else if (q[24] && !(&q[23:15])) begin
      r = -16'sh8000;
    end else begin
      r = q[15:0];
    end
    return r;
  endfunction

  assign dx = $signed({px, 1'b0}) - $signed({{2{pw[56]}}, pw});
  assign dy = $signed({py, 1'b0}) - $signed({{2{ph[56]}}, ph});

  assign left_next = corner(dx);
  assign top_next  = corner(dy);
  assign wid_next  = extent(pw);
  assign hei_next  = extent(ph);

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      left_x         <= left_next;
      top_y          <= top_next;
      box_width      <= wid_next;
      box_height     <= hei_next;
      class_index    <= s1_class;
      box_confidence <= s1_conf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

endmodule

`default_nettype wire
